@@ rtl/calf_pkg.sv @@
`default_nettype none

package calf_pkg;

    localparam int YEAR_LOW  = 69;
    localparam int YEAR_HIGH = 139;

    localparam int DAYS_W  = 18;
    localparam int HOURS_W = 22;
    localparam int MINS_W  = 28;
    localparam int PROD_W  = 34;
    localparam int SUM_W   = 35;

    localparam logic signed [31:0] DST_SECONDS = 32'sd3600;

    typedef struct packed {
        logic valid;
        logic err;
        logic dst;
    } t_ctl;

    // Days before the first of each month, minus one.
    function automatic logic signed [9:0] month_start(input logic [3:0] month);
        logic signed [9:0] md;
        case (month)
            4'd0:    md = -10'sd1;
            4'd1:    md = 10'sd30;
            4'd2:    md = 10'sd58;
            4'd3:    md = 10'sd89;
            4'd4:    md = 10'sd119;
            4'd5:    md = 10'sd150;
            4'd6:    md = 10'sd180;
            4'd7:    md = 10'sd211;
            4'd8:    md = 10'sd242;
            4'd9:    md = 10'sd272;
            4'd10:   md = 10'sd303;
            4'd11:   md = 10'sd333;
            4'd12:   md = 10'sd364;
            default: md = 10'sd0;
        endcase
        return md;
    endfunction

endpackage

`default_nettype wire

@@ rtl/calf_date.sv @@
`default_nettype none

module calf_date (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  i_valid,
    input  wire  [7:0]                           i_years_since_1900,
    input  wire  signed [7:0]                    i_month_index,
    input  wire  signed [10:0]                   i_day_of_month,
    input  wire  signed [10:0]                   i_hour_value,
    input  wire  signed [12:0]                   i_minute_value,
    input  wire  signed [12:0]                   i_second_value,
    input  wire                                  i_dst_active,
    output calf_pkg::t_ctl                       o_ctl,
    output logic signed [calf_pkg::DAYS_W-1:0]   o_days,
    output logic signed [10:0]                   o_hour,
    output logic signed [12:0]                   o_minute,
    output logic signed [12:0]                   o_second
);
    import calf_pkg::*;

    logic signed [9:0] month_off;
    logic [8:0]        month_pos;
    logic [17:0]       recip_prod;
    logic [4:0]        quot_off;
    logic [8:0]        quot_x12;
    logic [8:0]        month_rem;
    logic signed [9:0] year_fold;
    logic              n_err1;

    t_ctl              r_ctl1;
    logic [7:0]        r_year;
    logic [3:0]        r_month;
    logic signed [10:0] r_day;
    logic signed [10:0] r_hour1;
    logic signed [12:0] r_minute1;
    logic signed [12:0] r_second1;

    logic signed [DAYS_W-1:0] yy;
    logic signed [DAYS_W-1:0] n_days;
    logic                     leap_add;

    t_ctl                     r_ctl2;
    logic signed [DAYS_W-1:0] r_days;
    logic signed [10:0]       r_hour2;
    logic signed [12:0]       r_minute2;
    logic signed [12:0]       r_second2;

    // Floor division of the month by 12 through a reciprocal multiply on an offset value.
    always_comb begin
        month_off  = 10'(i_month_index) + 10'sd132;
        month_pos  = month_off[8:0];
        recip_prod = 18'(month_pos) * 18'd171;
        quot_off   = recip_prod[15:11];
        quot_x12   = 9'(quot_off) * 9'd12;
        month_rem  = month_pos - quot_x12;
        year_fold  = signed'({2'b00, i_years_since_1900}) + signed'({5'b00000, quot_off})
                     - 10'sd11;
        n_err1     = (i_years_since_1900 < 8'(YEAR_LOW)) ||
                     (i_years_since_1900 > 8'(YEAR_HIGH)) ||
                     (year_fold < 10'(YEAR_LOW)) || (year_fold > 10'(YEAR_HIGH));
    end

    always_comb begin
        yy       = signed'(DAYS_W'(r_year));
        leap_add = (r_year[1:0] == 2'b00) && (r_month > 4'd1);
        n_days   = (yy - DAYS_W'(70)) * DAYS_W'(365) + ((yy - DAYS_W'(1)) >>> 2)
                   - DAYS_W'(17) + DAYS_W'(month_start(r_month))
                   + DAYS_W'(leap_add) + DAYS_W'(r_day);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl1.valid <= 1'b0;
            r_ctl2.valid <= 1'b0;
        end else begin
            r_ctl1.valid <= i_valid;
            r_ctl2.valid <= r_ctl1.valid;
        end

        r_ctl1.err <= n_err1;
        r_ctl1.dst <= i_dst_active;
        r_year     <= year_fold[7:0];
        r_month    <= month_rem[3:0];
        r_day      <= i_day_of_month;
        r_hour1    <= i_hour_value;
        r_minute1  <= i_minute_value;
        r_second1  <= i_second_value;

        r_ctl2.err <= r_ctl1.err || (n_days < 0);
        r_ctl2.dst <= r_ctl1.dst;
        r_days     <= n_days;
        r_hour2    <= r_hour1;
        r_minute2  <= r_minute1;
        r_second2  <= r_second1;
    end

    assign o_ctl    = r_ctl2;
    assign o_days   = r_days;
    assign o_hour   = r_hour2;
    assign o_minute = r_minute2;
    assign o_second = r_second2;

endmodule

`default_nettype wire

@@ rtl/calf_time.sv @@
`default_nettype none

module calf_time (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  calf_pkg::t_ctl                       i_ctl,
    input  wire  signed [calf_pkg::DAYS_W-1:0]   i_days,
    input  wire  signed [10:0]                   i_hour,
    input  wire  signed [12:0]                   i_minute,
    input  wire  signed [12:0]                   i_second,
    output calf_pkg::t_ctl                       o_ctl,
    output logic signed [calf_pkg::PROD_W-1:0]   o_prod,
    output logic signed [12:0]                   o_second
);
    import calf_pkg::*;

    t_ctl                      r_ctl3;
    t_ctl                      r_ctl4;
    t_ctl                      r_ctl5;
    logic signed [HOURS_W-1:0] r_hours;
    logic signed [MINS_W-1:0]  r_mins;
    logic signed [PROD_W-1:0]  r_prod;
    logic signed [12:0]        r_minute3;
    logic signed [12:0]        r_second3;
    logic signed [12:0]        r_second4;
    logic signed [12:0]        r_second5;

    logic signed [HOURS_W-1:0] n_hours;
    logic signed [MINS_W-1:0]  n_mins;
    logic signed [PROD_W-1:0]  n_prod;

    always_comb begin
        n_hours = HOURS_W'(i_days) * HOURS_W'(24) + HOURS_W'(i_hour);
        n_mins  = MINS_W'(r_hours) * MINS_W'(60) + MINS_W'(r_minute3);
        n_prod  = PROD_W'(r_mins) * PROD_W'(60);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl3.valid <= 1'b0;
            r_ctl4.valid <= 1'b0;
            r_ctl5.valid <= 1'b0;
        end else begin
            r_ctl3.valid <= i_ctl.valid;
            r_ctl4.valid <= r_ctl3.valid;
            r_ctl5.valid <= r_ctl4.valid;
        end

        r_ctl3.err <= i_ctl.err;
        r_ctl3.dst <= i_ctl.dst;
        r_ctl4.err <= r_ctl3.err;
        r_ctl4.dst <= r_ctl3.dst;
        r_ctl5.err <= r_ctl4.err;
        r_ctl5.dst <= r_ctl4.dst;
        r_hours    <= n_hours;
        r_mins     <= n_mins;
        r_prod     <= n_prod;
        r_minute3  <= i_minute;
        r_second3  <= i_second;
        r_second4  <= r_second3;
        r_second5  <= r_second4;
    end

    assign o_ctl    = r_ctl5;
    assign o_prod   = r_prod;
    assign o_second = r_second5;

endmodule

`default_nettype wire

@@ rtl/calendar_fields_to_epoch_seconds.sv @@
// Converts broken-down calendar fields to signed 32-bit seconds since 1970-01-01 with an
// error flag. The block is a six-stage pipeline with no stalls: busy is always low, a word
// may be started on every clock, and its result is shown on o_strobe once it has passed
// through the date, time and output registers, in start order. The receiver must take each
// result in the cycle it is shown. On error o_epoch_seconds reads -1; a valid conversion
// may also give -1.
`default_nettype none

module calendar_fields_to_epoch_seconds (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 start,
    output logic                busy,
    input  wire  [7:0]          i_years_since_1900,
    input  wire  signed [7:0]   i_month_index,
    input  wire  signed [10:0]  i_day_of_month,
    input  wire  signed [10:0]  i_hour_value,
    input  wire  signed [12:0]  i_minute_value,
    input  wire  signed [12:0]  i_second_value,
    input  wire                 i_dst_active,
    output logic                o_strobe,
    output logic signed [31:0]  o_epoch_seconds,
    output logic                o_error
);
    import calf_pkg::*;

    t_ctl                     date_ctl;
    logic signed [DAYS_W-1:0] date_days;
    logic signed [10:0]       date_hour;
    logic signed [12:0]       date_minute;
    logic signed [12:0]       date_second;

    t_ctl                     time_ctl;
    logic signed [PROD_W-1:0] time_prod;
    logic signed [12:0]       time_second;

    logic signed [SUM_W-1:0]  sum;
    logic                     ovf;
    logic                     n_error;
    logic signed [31:0]       n_epoch;

    logic                     r_strobe;
    logic signed [31:0]       r_epoch;
    logic                     r_error;

    calf_date u_date (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (start && !busy),
        .i_years_since_1900 (i_years_since_1900),
        .i_month_index      (i_month_index),
        .i_day_of_month     (i_day_of_month),
        .i_hour_value       (i_hour_value),
        .i_minute_value     (i_minute_value),
        .i_second_value     (i_second_value),
        .i_dst_active       (i_dst_active),
        .o_ctl              (date_ctl),
        .o_days             (date_days),
        .o_hour             (date_hour),
        .o_minute           (date_minute),
        .o_second           (date_second)
    );

    calf_time u_time (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctl    (date_ctl),
        .i_days   (date_days),
        .i_hour   (date_hour),
        .i_minute (date_minute),
        .i_second (date_second),
        .o_ctl    (time_ctl),
        .o_prod   (time_prod),
        .o_second (time_second)
    );

    always_comb begin
        sum     = SUM_W'(time_prod) + SUM_W'(time_second);
        ovf     = (time_prod > PROD_W'(32'sh7FFF_FFFF)) || (time_prod < PROD_W'(32'sh8000_0000))
                  || (sum > SUM_W'(32'sh7FFF_FFFF)) || (sum < SUM_W'(32'sh8000_0000));
        n_error = time_ctl.err || ovf;
        if (n_error) begin
            n_epoch = -32'sd1;
        end else if (time_ctl.dst) begin
            n_epoch = sum[31:0] - DST_SECONDS;
        end else begin
            n_epoch = sum[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= time_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_epoch <= n_epoch;
        r_error <= n_error;
    end

    assign busy            = 1'b0;
    assign o_strobe        = r_strobe;
    assign o_epoch_seconds = r_epoch;
    assign o_error         = r_error;

endmodule

`default_nettype wire

@@ rtl/calf_checker.sv @@
`default_nettype none

module calf_checker (
    input wire                 i_clk,
    input wire                 i_rst_n,
    input wire                 start,
    input wire                 busy,
    input wire  [7:0]          i_years_since_1900,
    input wire                 o_strobe,
    input wire  signed [31:0]  o_epoch_seconds,
    input wire                 o_error
);
    import calf_pkg::*;

    a_never_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy == 1'b0)
        else $error("busy raised on a pipeline that never stalls");

    a_start_gives_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##6 o_strobe)
        else $error("accepted word produced no result six cycles later");

    a_no_spurious_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(start && !busy) |-> ##6 !o_strobe)
        else $error("result strobe without a matching accepted word");

    a_error_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_error) |-> (o_epoch_seconds == -32'sd1))
        else $error("error result does not read minus one");

    a_bad_year: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy && ((i_years_since_1900 < 8'(YEAR_LOW)) ||
                            (i_years_since_1900 > 8'(YEAR_HIGH)))) |-> ##6 o_error)
        else $error("year out of range not flagged");

endmodule

bind calendar_fields_to_epoch_seconds calf_checker u_calf_checker (.*);

`default_nettype wire
